// ----- hw/rtl/rech_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rech_pkg: random excursion cycle histogram definitions
// Payload structs, cell control group and fixed constants shared by the
// cell row and the top level.
// ----------------------------------------------------------------------------
package rech_pkg;

   localparam int CNT_W       = 25;
   localparam int NUM_STATES  = 8;
   localparam int NUM_BUCKETS = 6;
   localparam int VISIT_W     = 3;
   localparam int STATE_W     = 3;
   localparam int BUCKET_W    = 3;

   localparam logic [VISIT_W-1:0]  VISIT_SAT      = 3'd5;
   localparam logic [CNT_W-1:0]    CNT_MAX        = {CNT_W{1'b1}};
   localparam logic [CNT_W-1:0]    MIN_CYCLES_RST = 25'd500;
   localparam logic [STATE_W-1:0]  LAST_STATE     = 3'd7;
   localparam logic [BUCKET_W-1:0] LAST_BUCKET    = 3'd5;

   typedef struct packed {
      logic bit_req;
      logic last;
   } req_type;

   typedef struct packed {
      logic [STATE_W-1:0]  state_index;
      logic [BUCKET_W-1:0] visit_bucket;
      logic [CNT_W-1:0]    bucket_count;
      logic [CNT_W-1:0]    total_cycles;
      logic                too_few_cycles;
      logic                last_result;
   } rsp_type;

   // Control broadcast along the cell row
   typedef struct packed {
      logic step;   // a sequence bit is transferred this cycle
      logic close;  // the current cycle closes on this bit
      logic shift;  // drain: move bucket counts one place towards cell 0
   } cell_ctl_type;

endpackage

// ----- hw/rtl/rech_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rech_cell: one walk state of the excursion histogram
// Holds the visit counter and the six bucket counts of one state; the bucket
// counts form a segment of the drain shift chain.
// ----------------------------------------------------------------------------
module rech_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  rech_pkg::cell_ctl_type    ctl,
   input  logic                      hit,
   input  logic [rech_pkg::CNT_W-1:0] shift_in,
   output logic [rech_pkg::CNT_W-1:0] shift_out
);
   import rech_pkg::*;

   logic [VISIT_W-1:0] visit_ff, visit_in, visit_eff;
   logic [CNT_W-1:0]   bucket_ff [NUM_BUCKETS];
   logic [CNT_W-1:0]   bucket_in [NUM_BUCKETS];

   // visit count including this bit's visit, saturating
   assign visit_eff = (hit && (visit_ff < VISIT_SAT)) ? VISIT_W'(visit_ff + 1'b1) : visit_ff;
   assign shift_out = bucket_ff[0];

   always_comb begin
      visit_in = visit_ff;
      for (int j = 0; j < NUM_BUCKETS; j++) begin
         bucket_in[j] = bucket_ff[j];
      end
      if (ctl.shift) begin
         for (int j = 0; j < NUM_BUCKETS - 1; j++) begin
            bucket_in[j] = bucket_ff[j+1];
         end
         bucket_in[NUM_BUCKETS-1] = shift_in;
      end else if (ctl.close) begin
         visit_in = '0;
         for (int j = 0; j < NUM_BUCKETS; j++) begin
            if ((visit_eff == VISIT_W'(j)) && (bucket_ff[j] != CNT_MAX)) begin
               bucket_in[j] = CNT_W'(bucket_ff[j] + 1'b1);
            end
         end
      end else if (ctl.step) begin
         visit_in = visit_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visit_ff <= '0;
         for (int j = 0; j < NUM_BUCKETS; j++) begin
            bucket_ff[j] <= '0;
         end
      end else begin
         visit_ff <= visit_in;
         for (int j = 0; j < NUM_BUCKETS; j++) begin
            bucket_ff[j] <= bucket_in[j];
         end
      end
   end

endmodule

// ----- hw/rtl/random_excursion_cycle_histogram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_excursion_cycle_histogram: excursion cycle counting stage
// Random walk over a bit stream with per-state visit histograms per cycle,
// drained as 48 bucket counts at the end of each sequence.
// ----------------------------------------------------------------------------
//
//   port group  | dir | handshake           | payload
//   ------------+-----+---------------------+-------------------------------
//   req_        | in  | req_valid/req_ready | req_type: bit_req, last
//   rsp_        | out | rsp_valid/rsp_ready | rsp_type: 48 bucket results
//   csr_        | in  | csr_wr_en           | csr_wr_data: min_cycles
//
// Cycles: one bit transfer per clock while running. A bit marked last is
// followed by a drain phase of 48 result transfers, one per clock when
// rsp_ready stays high; req_ready is low for the whole drain, so no new bits
// are taken before the last result is out. The drain is a shift through the cell row:
// cell 0 presents its bucket 0, and every transfer moves the row along by
// one place and shifts in zeros, which also clears the table.
// Reset (synchronous) clears walk, counters and table; min_cycles goes to 500.
// A stall on rsp_ready simply holds the row and the result indices.
// ----------------------------------------------------------------------------
module random_excursion_cycle_histogram #(
   parameter int LOG_MAX_BITS = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  rech_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rech_pkg::rsp_type          rsp_data,
   input  logic                       csr_wr_en,
   input  logic [rech_pkg::CNT_W-1:0] csr_wr_data
);
   import rech_pkg::*;

   localparam int WALK_W = LOG_MAX_BITS + 2;
   // walk saturates at +/-(2^(LOG_MAX_BITS+1) - 1)
   localparam logic signed [WALK_W-1:0] WALK_LIM  = {1'b0, {(LOG_MAX_BITS+1){1'b1}}};
   localparam logic signed [WALK_W-1:0] WALK_NLIM = -WALK_LIM;
   localparam logic signed [WALK_W-1:0] WALK_LO   = -WALK_W'(4);
   localparam logic signed [WALK_W-1:0] WALK_HI   = WALK_W'(4);

   // two phases: taking bits, and draining the histogram
   typedef enum logic [1:0] {
      ST_RUN   = 2'b01,
      ST_DRAIN = 2'b10
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic signed [WALK_W-1:0] walk_ff, walk_in, walk_step;
   logic [CNT_W-1:0]     total_ff, total_in;
   logic [CNT_W-1:0]     min_cycles_ff, min_cycles_in;
   logic [STATE_W-1:0]   st_idx_ff, st_idx_in;
   logic [BUCKET_W-1:0]  bkt_idx_ff, bkt_idx_in;

   logic                 req_xfer, rsp_xfer, rsp_final;
   logic                 at_zero, in_window;
   logic [STATE_W-1:0]   hit_idx;
   logic [NUM_STATES-1:0] hit_vec;
   cell_ctl_type         ctl;
   logic [CNT_W-1:0]     link [NUM_STATES+1];

   assign req_ready = (phase_ff == ST_RUN);
   assign rsp_valid = (phase_ff == ST_DRAIN);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid && rsp_ready;
   assign rsp_final = (st_idx_ff == LAST_STATE) && (bkt_idx_ff == LAST_BUCKET);

   // ---- walk: saturating step up for a one, down for a zero
   always_comb begin
      if (req_data.bit_req) begin
         walk_step = (walk_ff < WALK_LIM) ? WALK_W'(walk_ff + 1'b1) : walk_ff;
      end else begin
         walk_step = (walk_ff > WALK_NLIM) ? WALK_W'(walk_ff - 1'b1) : walk_ff;
      end
   end

   assign at_zero   = (walk_step == '0);
   assign in_window = !at_zero && (walk_step >= WALK_LO) && (walk_step <= WALK_HI);
   // -4..-1 map to 0..3, 1..4 map to 4..7
   assign hit_idx   = walk_step[WALK_W-1] ? STATE_W'(walk_step[STATE_W-1:0] + 3'd4)
                                          : STATE_W'(walk_step[STATE_W-1:0] + 3'd3);

   always_comb begin
      hit_vec = '0;
      hit_vec[hit_idx] = in_window;
   end

   // a return to zero closes the cycle; the final bit closes the partial one
   assign ctl.step  = req_xfer;
   assign ctl.close = req_xfer && (at_zero || req_data.last);
   assign ctl.shift = rsp_xfer;

   // ---- cell row, drain chain runs towards cell 0, zeros enter at the far end
   assign link[NUM_STATES] = '0;

   for (genvar i = 0; i < NUM_STATES; i++) begin : g_cell
      rech_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .hit       (hit_vec[i]),
         .shift_in  (link[i+1]),
         .shift_out (link[i])
      );
   end

   // ---- sequencing
   always_comb begin
      phase_in      = phase_ff;
      walk_in       = walk_ff;
      total_in      = total_ff;
      st_idx_in     = st_idx_ff;
      bkt_idx_in    = bkt_idx_ff;
      min_cycles_in = csr_wr_en ? csr_wr_data : min_cycles_ff;

      unique case (phase_ff)
         ST_RUN: begin
            if (req_xfer) begin
               walk_in = req_data.last ? '0 : walk_step;
               if (ctl.close && (total_ff != CNT_MAX)) begin
                  total_in = CNT_W'(total_ff + 1'b1);
               end
               if (req_data.last) begin
                  phase_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_xfer) begin
               if (rsp_final) begin
                  phase_in   = ST_RUN;
                  total_in   = '0;
                  st_idx_in  = '0;
                  bkt_idx_in = '0;
               end else if (bkt_idx_ff == LAST_BUCKET) begin
                  bkt_idx_in = '0;
                  st_idx_in  = STATE_W'(st_idx_ff + 1'b1);
               end else begin
                  bkt_idx_in = BUCKET_W'(bkt_idx_ff + 1'b1);
               end
            end
         end
         default: begin
            phase_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= ST_RUN;
         walk_ff       <= '0;
         total_ff      <= '0;
         st_idx_ff     <= '0;
         bkt_idx_ff    <= '0;
         min_cycles_ff <= MIN_CYCLES_RST;
      end else begin
         phase_ff      <= phase_in;
         walk_ff       <= walk_in;
         total_ff      <= total_in;
         st_idx_ff     <= st_idx_in;
         bkt_idx_ff    <= bkt_idx_in;
         min_cycles_ff <= min_cycles_in;
      end
   end

   // ---- result: head of the chain plus the held totals
   assign rsp_data.state_index    = st_idx_ff;
   assign rsp_data.visit_bucket   = bkt_idx_ff;
   assign rsp_data.bucket_count   = link[0];
   assign rsp_data.total_cycles   = total_ff;
   assign rsp_data.too_few_cycles = (total_ff < min_cycles_ff);
   assign rsp_data.last_result    = rsp_final;

   // ---- checks
   a_phase_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("result and bit transfers enabled together");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_data.last) |=> (rsp_valid && st_idx_ff == '0 && bkt_idx_ff == '0))
      else $error("drain did not start at the first result after a final bit");

   a_drain_walk_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (walk_ff == '0))
      else $error("walk not cleared during drain");

   a_final_returns: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_final) |=> (req_ready && total_ff == '0 && link[0] == '0))
      else $error("stores not cleared after final result transfer");

endmodule
